/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds on every edge out of reset
`define XBC_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);
// pre on one edge implies post on the next
`define XBC_ASSERT_NEXT(lbl, ck, rstn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define XBC_ASSERT(lbl, ck, rstn, prop, msg)
`define XBC_ASSERT_NEXT(lbl, ck, rstn, pre, post, msg)
`endif
`endif

/* hdl/xbc_pkg.sv */
// ----------------------------------------------------------------------------
// XTEA package
// Shared types and constants of the XTEA block cipher core.
// ----------------------------------------------------------------------------
package xbc_pkg;

	typedef logic [31:0]      word_t;
	typedef logic [3:0][31:0] key_t;
	typedef logic [1:0]       cfg_idx_t;

	// command codes
	localparam logic CMD_ENC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	// configuration register indexes
	localparam cfg_idx_t KEY_IDX_0 = 2'd0;
	localparam cfg_idx_t KEY_IDX_1 = 2'd1;
	localparam cfg_idx_t KEY_IDX_2 = 2'd2;
	localparam cfg_idx_t KEY_IDX_3 = 2'd3;

	// golden ratio step; adding it equals subtracting 0x61C88647
	localparam word_t DELTA = 32'h9E37_79B9;

	// one block in flight
	typedef struct packed {
		logic  cmd;
		word_t v0;
		word_t v1;
	} blk_t;

endpackage

/* hdl/xbc_if.sv */
// ----------------------------------------------------------------------------
// XTEA channel interfaces
// Valid/ready channels for input blocks, result blocks and key writes.
// ----------------------------------------------------------------------------
interface xbc_in_if
	import xbc_pkg::*;
	;
	logic  valid;
	logic  ready;
	logic  cmd;
	word_t first_word;
	word_t second_word;

	modport source (output valid, cmd, first_word, second_word, input ready);
	modport sink   (input valid, cmd, first_word, second_word, output ready);
endinterface

interface xbc_out_if
	import xbc_pkg::*;
	;
	logic  valid;
	logic  ready;
	word_t first_word_out;
	word_t second_word_out;

	modport source (output valid, first_word_out, second_word_out, input ready);
	modport sink   (input valid, first_word_out, second_word_out, output ready);
endinterface

interface xbc_cfg_if
	import xbc_pkg::*;
	;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	word_t    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/xbc_key_regs.sv */
// ----------------------------------------------------------------------------
// XTEA key registers
// Four 32-bit key words written through the configuration channel.
// ----------------------------------------------------------------------------
module xbc_key_regs
	import xbc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	xbc_cfg_if.sink   cfg,
	output key_t      key
);

	key_t key_q;

	assign cfg.ready = 1'b1;
	assign key       = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				KEY_IDX_0: key_q[0] <= cfg.data;
				KEY_IDX_1: key_q[1] <= cfg.data;
				KEY_IDX_2: key_q[2] <= cfg.data;
				KEY_IDX_3: key_q[3] <= cfg.data;
				default:   key_q    <= key_q;
			endcase
		end
	end

endmodule

/* hdl/xbc_stage.sv */
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One Feistel half-round, encrypt or decrypt, with its own valid register.
// ----------------------------------------------------------------------------
module xbc_stage
	import xbc_pkg::*;
#(
	parameter int ROUNDS = 32,
	parameter int STAGE  = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  key_t  key,
	input  logic  in_vld,
	input  blk_t  in_data,
	output logic  in_rdy,
	output logic  out_vld,
	output blk_t  out_data,
	input  logic  out_rdy
);

	// sum seen by this half-round, fixed at elaboration
	localparam int          RND_IDX = (STAGE + 1) / 2;
	localparam logic        ODD     = 1'((STAGE % 2) != 0);
	localparam logic [63:0] ENC_P   = 64'(RND_IDX) * 64'(DELTA);
	localparam logic [63:0] DEC_P   = 64'(ROUNDS - RND_IDX) * 64'(DELTA);
	localparam word_t       ENC_SUM = ENC_P[31:0];
	localparam word_t       DEC_SUM = DEC_P[31:0];
	// encrypt takes sum[1:0] on even stages, decrypt on odd ones
	localparam logic [1:0]  ENC_KI  = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
	localparam logic [1:0]  DEC_KI  = ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

	logic  vld_s1;
	blk_t  data_s1;
	logic  tgt_v0;
	word_t src, tgt, mix, sk, f, upd;
	blk_t  nxt;

	always_comb begin
		// even encrypt and odd decrypt update v0
		tgt_v0 = (in_data.cmd == ODD);
		src    = tgt_v0 ? in_data.v1 : in_data.v0;
		tgt    = tgt_v0 ? in_data.v0 : in_data.v1;
		mix    = ((src << 4) ^ (src >> 5)) + src;
		sk     = (in_data.cmd == CMD_DEC) ? (DEC_SUM + key[DEC_KI])
		                                  : (ENC_SUM + key[ENC_KI]);
		f      = mix ^ sk;
		upd    = (in_data.cmd == CMD_DEC) ? (tgt - f) : (tgt + f);
		nxt    = in_data;
		if (tgt_v0) begin
			nxt.v0 = upd;
		end else begin
			nxt.v1 = upd;
		end
	end

	assign in_rdy   = !vld_s1 || out_rdy;
	assign out_vld  = vld_s1;
	assign out_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld && in_rdy) begin
			data_s1 <= nxt;
		end
	end

endmodule

/* hdl/xtea_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// XTEA block cipher core
// Pipelined XTEA, ECB, one 64-bit block per cycle either way unless dout stalls.
// ----------------------------------------------------------------------------
//  channel  dir  fields                          role
//  din      in   cmd, first_word, second_word    block to encrypt/decrypt
//  dout     out  first_word_out, second_word_out processed block
//  cfg      in   index, data                     key word write
//
//  Every Feistel half-round has its own register stage. A new word
//  is taken every cycle unless a stall on dout backs up to din.
//  Reset clears every stage valid bit and the key words to zero.
//  Ready ripples back stage by stage, so a stall on dout holds the
//  stalled words in place while empty stages upstream keep filling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xtea_block_cipher_core
	import xbc_pkg::*;
#(
	parameter int ROUNDS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	xbc_in_if.sink     din,
	xbc_out_if.source  dout,
	xbc_cfg_if.sink    cfg
);

	localparam int NSTG = 2 * ROUNDS;

	key_t key;

	// per-stage pipeline view: vld/data are stage outputs, rdy[i] is
	// the ready seen by the producer feeding stage i
	logic vld  [NSTG];
	blk_t data [NSTG];
	logic rdy  [NSTG+1];
	blk_t din_blk;

	xbc_key_regs u_keys (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.key    (key)
	);

	assign din_blk.cmd = din.cmd;
	assign din_blk.v0  = din.first_word;
	assign din_blk.v1  = din.second_word;
	assign din.ready   = rdy[0];
	assign rdy[NSTG]   = dout.ready;

	for (genvar i = 0; i < NSTG; i++) begin : g_stage
		logic in_vld;
		blk_t in_data;
		if (i == 0) begin : g_head
			assign in_vld  = din.valid;
			assign in_data = din_blk;
		end else begin : g_body
			assign in_vld  = vld[i-1];
			assign in_data = data[i-1];
		end

		xbc_stage #(
			.ROUNDS (ROUNDS),
			.STAGE  (i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.in_vld   (in_vld),
			.in_data  (in_data),
			.in_rdy   (rdy[i]),
			.out_vld  (vld[i]),
			.out_data (data[i]),
			.out_rdy  (rdy[i+1])
		);
	end

	assign dout.valid           = vld[NSTG-1];
	assign dout.first_word_out  = data[NSTG-1].v0;
	assign dout.second_word_out = data[NSTG-1].v1;

	// accepted word lands in the first stage
	`XBC_ASSERT_NEXT(a_head_fill, clk, arst_n, din.valid && din.ready, vld[0], "word not captured")
	// the second-to-last stage, full and facing a stalled successor, keeps its word
	`XBC_ASSERT_NEXT(a_stage_hold, clk, arst_n, vld[NSTG-2] && !rdy[NSTG-1], vld[NSTG-2] && $stable(data[NSTG-2]), "stalled stage lost its word")
	// a key write to key word 2 reaches that key word
	`XBC_ASSERT_NEXT(a_key_write, clk, arst_n, cfg.valid && cfg.ready && (cfg.index == KEY_IDX_2), key[KEY_IDX_2] == $past(cfg.data), "key write missed")

endmodule

/* bench/xtea_block_cipher_core_tb.sv */
// ----------------------------------------------------------------------------
// XTEA block cipher core testbench
// Drives 64-bit blocks through the pipelined core under several keys and
// random idle patterns on both channels. Each result word is checked
// against a cycle-free XTEA predictor that tracks the key registers.
// ----------------------------------------------------------------------------
module xtea_block_cipher_core_tb
	import xbc_pkg::*;
	;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CIPHER_ROUNDS = 32;
	// pipeline depth: one stage per half-round
	localparam int PIPE_DEPTH    = 2 * CIPHER_ROUNDS;
	localparam int PRINT_LIMIT   = 50;

	// one processed block as the core should return it
	typedef struct {
		word_t w0;
		word_t w1;
	} block_pair_t;

	logic clk;
	logic arst_n;

	xbc_in_if  din_if ();
	xbc_out_if dout_if ();
	xbc_cfg_if cfg_if ();

	xtea_block_cipher_core #(
		.ROUNDS(CIPHER_ROUNDS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if),
		.cfg   (cfg_if)
	);

	// key words as the core should hold them; reset clears them
	key_t        key_model;
	// ciphertext/plaintext blocks still owed by the core, oldest first
	block_pair_t pending_blocks[$];
	int          error_count;
	// idle chance, in percent, of the block sender and the result receiver
	int          src_idle_pct;
	int          snk_idle_pct;

	// register index for each key word, in key order
	const cfg_idx_t key_index[4] = '{KEY_IDX_0, KEY_IDX_1, KEY_IDX_2, KEY_IDX_3};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the core hangs
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic word_t feistel_mix(input word_t v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

	// XTEA on one block with the current key model; sum[1:0] picks the key
	// word for the v0 half, sum[12:11] for the v1 half
	function automatic block_pair_t xtea_predict(input logic cmd, input word_t a,
			input word_t b);
		block_pair_t res;
		word_t       sum;
		res.w0 = a;
		res.w1 = b;
		if (cmd == CMD_ENC) begin
			sum = '0;
			for (int r = 0; r < CIPHER_ROUNDS; r++) begin
				res.w0 += feistel_mix(res.w1) ^ (sum + key_model[sum[1:0]]);
				sum    += DELTA;
				res.w1 += feistel_mix(res.w0) ^ (sum + key_model[sum[12:11]]);
			end
		end else begin
			// start from ROUNDS * DELTA mod 2^32 and walk back
			sum = '0;
			repeat (CIPHER_ROUNDS) sum += DELTA;
			for (int r = 0; r < CIPHER_ROUNDS; r++) begin
				res.w1 -= feistel_mix(res.w0) ^ (sum + key_model[sum[12:11]]);
				sum    -= DELTA;
				res.w0 -= feistel_mix(res.w1) ^ (sum + key_model[sum[1:0]]);
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Reporting
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Result receiver and checker. Ready is redrawn every cycle; a word
	// moves when valid and ready were both high at the edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		block_pair_t want;
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			if (dout_if.valid && dout_if.ready) begin
				if (pending_blocks.size() == 0) begin
					report_mismatch($sformatf("unexpected block %h %h",
						dout_if.first_word_out, dout_if.second_word_out));
				end else begin
					want = pending_blocks.pop_front();
					if (dout_if.first_word_out !== want.w0)
						report_mismatch($sformatf("first_word_out %h, want %h",
							dout_if.first_word_out, want.w0));
					if (dout_if.second_word_out !== want.w1)
						report_mismatch($sformatf("second_word_out %h, want %h",
							dout_if.second_word_out, want.w1));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Shared stimulus tasks
	// ------------------------------------------------------------------

	// Send one block. Valid stays high from one word to the next unless an
	// idle gap is drawn, so back-to-back words never drop valid.
	task automatic send_block(input logic cmd, input word_t a, input word_t b);
		if ($urandom_range(99) < src_idle_pct) begin
			din_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		din_if.valid       <= 1'b1;
		din_if.cmd         <= cmd;
		din_if.first_word  <= a;
		din_if.second_word <= b;
		do @(posedge clk); while (!din_if.ready);
		// accepted at this edge: queue what it must turn into
		pending_blocks.push_back(xtea_predict(cmd, a, b));
	endtask

	// Stop sending and wait until every owed result has come back.
	// It always waits for the clock, so a following send never drives
	// valid twice in one step.
	task automatic drain_results();
		din_if.valid <= 1'b0;
		do @(posedge clk); while (pending_blocks.size() != 0);
	endtask

	// Write the key words picked by mask; the pipeline must be empty.
	task automatic load_key(input key_t value, input logic [3:0] mask);
		for (int i = 0; i < 4; i++) begin
			if (mask[i]) begin
				cfg_if.valid <= 1'b1;
				cfg_if.index <= key_index[i];
				cfg_if.data  <= value[i];
				do @(posedge clk); while (!cfg_if.ready);
				key_model[key_index[i]] = value[i];
			end
		end
		cfg_if.valid <= 1'b0;
	endtask

	// Mostly uniform words, with a share of corner patterns mixed in
	function automatic word_t pick_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return word_t'(1) << $urandom_range(31);
			3:       return ~(word_t'(1) << $urandom_range(31));
			default: return $urandom;
		endcase
	endfunction

	function automatic key_t random_key();
		key_t k;
		for (int i = 0; i < 4; i++) k[i] = pick_word();
		return k;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Corner blocks in both directions under the reset key, an all-ones key
	// and a mixed key, plus one encrypt/decrypt round trip.
	task automatic test_corner_blocks();
		key_t        mixed;
		block_pair_t ct;
		src_idle_pct = 38;
		snk_idle_pct = 52;
		// key is still zero from reset
		send_block(CMD_ENC, 32'h0000_0000, 32'h0000_0000);
		send_block(CMD_DEC, 32'h0000_0000, 32'h0000_0000);
		send_block(CMD_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(CMD_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_results();

		load_key('1, 4'b1111);
		send_block(CMD_ENC, 32'h0000_0000, 32'h0000_0000);
		send_block(CMD_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(CMD_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(CMD_ENC, 32'h8000_0000, 32'h0000_0001);
		send_block(CMD_DEC, 32'h0000_0001, 32'h8000_0000);
		send_block(CMD_ENC, 32'hAAAA_AAAA, 32'h5555_5555);
		drain_results();

		mixed = {32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210};
		load_key(mixed, 4'b1111);
		send_block(CMD_ENC, 32'h4142_4344, 32'h4546_4748);
		send_block(CMD_DEC, 32'h5555_5555, 32'hAAAA_AAAA);
		// round trip: decrypting the ciphertext must give the block back
		ct = xtea_predict(CMD_ENC, 32'hDEAD_BEEF, 32'h0BAD_F00D);
		send_block(CMD_ENC, 32'hDEAD_BEEF, 32'h0BAD_F00D);
		send_block(CMD_DEC, ct.w0, ct.w1);
		drain_results();
	endtask

	// Each key word written on its own, with one block each way after it,
	// so a swapped register index shows up.
	task automatic test_key_word_select();
		key_t k;
		load_key('0, 4'b1111);
		drain_results();
		for (int i = 0; i < 4; i++) begin
			k    = '0;
			k[i] = $urandom | 32'h1;
			load_key(k, 4'b0001 << i);
			send_block(CMD_ENC, pick_word(), pick_word());
			send_block(CMD_DEC, pick_word(), pick_word());
			drain_results();
		end
	endtask

	// One phase of random traffic under a fresh random key. Part of the
	// blocks come as round trips; halfway the sender holds off until the
	// pipeline has fully drained.
	task automatic test_random_traffic(input int n_blocks, input int src_pct,
			input int snk_pct);
		int          sent;
		block_pair_t ct;
		word_t       a;
		word_t       b;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		drain_results();
		load_key(random_key(), 4'b1111);
		sent = 0;
		while (sent < n_blocks) begin
			a = pick_word();
			b = pick_word();
			if ($urandom_range(4) == 0) begin
				ct = xtea_predict(CMD_ENC, a, b);
				send_block(CMD_ENC, a, b);
				send_block(CMD_DEC, ct.w0, ct.w1);
				sent += 2;
			end else begin
				send_block($urandom_range(1) ? CMD_DEC : CMD_ENC, a, b);
				sent++;
			end
			if (sent >= n_blocks / 2 && sent < n_blocks / 2 + 2)
				drain_results();
		end
		drain_results();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		error_count        = 0;
		key_model          = '0;
		src_idle_pct       = 0;
		snk_idle_pct       = 0;
		arst_n             = 1'b0;
		din_if.valid       = 1'b0;
		din_if.cmd         = CMD_ENC;
		din_if.first_word  = '0;
		din_if.second_word = '0;
		dout_if.ready      = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = KEY_IDX_0;
		cfg_if.data        = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_blocks();
		test_key_word_select();
		// receiver-heavy idling, then sender-heavy, then full rate
		test_random_traffic(680, 38, 52);
		test_random_traffic(680, 52, 38);
		test_random_traffic(680, 0, 0);

		// let any stray word surface past the pipeline depth
		repeat (PIPE_DEPTH + 16) @(posedge clk);
		if (pending_blocks.size() != 0)
			report_mismatch($sformatf("%0d results never arrived",
				pending_blocks.size()));

		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/xbc_pkg.sv
hdl/xbc_if.sv
hdl/xbc_key_regs.sv
hdl/xbc_stage.sv
hdl/xtea_block_cipher_core.sv
bench/xtea_block_cipher_core_tb.sv
